// ----- design/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions of the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = 3;
  localparam int POS_W        = 6;
  localparam int RND_W        = 7;
  localparam int LEN_W        = 64;
  localparam int LEN_CNT_W    = 3;
  localparam int DIGEST_WORDS = 5;
  localparam int WIN_WORDS    = 16;

  typedef logic [WORD_W-1:0] word_t;

  // fixed positions and codes
  localparam logic [POS_W-1:0]     BLOCK_LAST_POS = 6'd63;
  localparam logic [POS_W-1:0]     LEN_POS        = 6'd56;
  localparam logic [RND_W-1:0]     LAST_ROUND     = 7'd79;
  localparam logic [RND_W-1:0]     PHASE1_START   = 7'd20;
  localparam logic [RND_W-1:0]     PHASE2_START   = 7'd40;
  localparam logic [RND_W-1:0]     PHASE3_START   = 7'd60;
  localparam logic [LEN_CNT_W-1:0] LEN_BYTE_LAST  = 3'd7;
  localparam logic [IDX_W-1:0]     LAST_WORD_IDX  = 3'd4;
  localparam logic [BYTE_W-1:0]    PAD_MARK       = 8'h80;
  localparam logic [BYTE_W-1:0]    PAD_ZERO       = 8'h00;
  localparam logic [LEN_W-1:0]     BITS_PER_BYTE  = 64'd8;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // control from the sequencer to the compression unit
  typedef struct packed {
    logic              wr_en;
    logic [POS_W-1:0]  wr_pos;
    logic [BYTE_W-1:0] wr_byte;
    logic              start;
    logic              reinit;
  } ctl_t;

  // status back from the compression unit
  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  // round function by phase
  function automatic word_t round_f(input logic [RND_W-1:0] rnd,
                                    input word_t b, input word_t c, input word_t d);
    word_t f;
    if (rnd < PHASE1_START) begin
      f = (b & c) | (~b & d);
    end else if (rnd < PHASE2_START) begin
      f = b ^ c ^ d;
    end else if (rnd < PHASE3_START) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // round constant by phase
  function automatic word_t round_k(input logic [RND_W-1:0] rnd);
    word_t k;
    if (rnd < PHASE1_START) begin
      k = K0;
    end else if (rnd < PHASE2_START) begin
      k = K1;
    end else if (rnd < PHASE3_START) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- design/sha1md_if.sv -----
// ----------------------------------------------------------------------------
// sha1md channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1md_in_if;
  logic                         valid;
  logic                         ready;
  logic [sha1md_pkg::BYTE_W-1:0] data_byte;
  logic                         byte_present;
  logic                         end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic                          valid;
  logic                          ready;
  logic [sha1md_pkg::WORD_W-1:0] digest_word;
  logic [sha1md_pkg::IDX_W-1:0]  word_index;
  logic                          last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ----- design/sha1md_compress.sv -----
// ----------------------------------------------------------------------------
// sha1md_compress
// Message window, chaining words and the shared SHA-1 round unit: one round
// per cycle over 80 rounds, then a fold into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_compress (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha1md_pkg::ctl_t  ctl_i,
  output sha1md_pkg::stat_t      stat_o,
  output sha1md_pkg::word_t      chain_o [sha1md_pkg::DIGEST_WORDS]
);
  import sha1md_pkg::*;

  word_t            win_r   [WIN_WORDS];
  word_t            chain_r [DIGEST_WORDS];
  word_t            a_r, b_r, c_r, d_r, e_r;
  logic [RND_W-1:0] rnd_r;
  logic             running_r;
  logic             fold_r;

  word_t            sum_w;
  logic [3:0]       wr_word;
  logic [1:0]       wr_lane;
  logic [4:0]       lane_lsb;

  // one round of the compression function, and the byte write position decode
  always_comb begin
    sum_w   = {a_r[WORD_W-6:0], a_r[WORD_W-1:WORD_W-5]} + round_f(rnd_r, b_r, c_r, d_r)
              + e_r + round_k(rnd_r) + win_r[0];
    wr_word = ctl_i.wr_pos[POS_W-1:2];
    wr_lane = ctl_i.wr_pos[1:0];
    lane_lsb = {~wr_lane, 3'b000};
  end

  // window: byte writes while idle, shifting during rounds
  always_ff @(posedge clk) begin
    if (running_r) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_WORDS-1] <= {win_r[13][WORD_W-2:0] ^ win_r[8][WORD_W-2:0] ^
                             win_r[2][WORD_W-2:0] ^ win_r[0][WORD_W-2:0],
                             win_r[13][WORD_W-1] ^ win_r[8][WORD_W-1] ^
                             win_r[2][WORD_W-1] ^ win_r[0][WORD_W-1]};
    end else if (ctl_i.wr_en) begin
      if (wr_lane == 2'd0) begin
        win_r[wr_word] <= {ctl_i.wr_byte, {(WORD_W-BYTE_W){1'b0}}};
      end else begin
        win_r[wr_word][lane_lsb +: BYTE_W] <= ctl_i.wr_byte;
      end
    end
  end

  // working words
  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (running_r) begin
      a_r <= sum_w;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[WORD_W-1:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // round sequencing and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      fold_r    <= 1'b0;
      rnd_r     <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= INIT_H[i];
      end
    end else begin
      if (ctl_i.start) begin
        running_r <= 1'b1;
        rnd_r     <= '0;
      end else if (running_r) begin
        if (rnd_r == LAST_ROUND) begin
          running_r <= 1'b0;
          fold_r    <= 1'b1;
          rnd_r     <= '0;
        end else begin
          rnd_r <= rnd_r + 1'b1;
        end
      end
      if (fold_r) begin
        fold_r     <= 1'b0;
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end else if (ctl_i.reinit) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_r[i] <= INIT_H[i];
        end
      end
    end
  end

  assign stat_o.busy = running_r | fold_r;
  assign stat_o.done = fold_r;

  always_comb begin
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      chain_o[i] = chain_r[i];
    end
  end

endmodule

`default_nettype wire

// ----- design/sha1_message_digest.sv -----
// Message bytes are taken one per cycle while idle; a filled 64-byte block is then
// compressed (80 rounds on the shared round unit, one fold) and no bytes are taken
// meanwhile. An end mark pads one byte per cycle with one or two further blocks,
// then gives five words, one a cycle while the receiver is ready.
// Reset: chaining words to the initial hash, counters and length to zero.
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream: packing, length count, padding and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1md_in_if.sink   in_ch,
  sha1md_out_if.source out_ch
);
  import sha1md_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COMP = 4'b0010,
    S_PAD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      count_r, count_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  padding_r, padding_nxt;
  logic                  mark_done_r, mark_done_nxt;
  logic                  len_act_r, len_act_nxt;
  logic [LEN_CNT_W-1:0]  len_cnt_r, len_cnt_nxt;
  logic                  pad_last_r, pad_last_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;

  ctl_t                  ctl;
  stat_t                 stat;
  word_t                 chain [DIGEST_WORDS];

  // compression unit
  sha1md_compress u_compress (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl),
    .stat_o  (stat),
    .chain_o (chain)
  );

  // sequencer: byte intake, padding, output
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    padding_nxt   = padding_r;
    mark_done_nxt = mark_done_r;
    len_act_nxt   = len_act_r;
    len_cnt_nxt   = len_cnt_r;
    pad_last_nxt  = pad_last_r;
    out_idx_nxt   = out_idx_r;
    ctl           = '0;
    ctl.wr_pos    = count_r;
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          padding_nxt = in_ch.end_of_message;
          if (in_ch.byte_present) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_byte = in_ch.data_byte;
            count_nxt   = count_r + 1'b1;
            len_nxt     = len_r + BITS_PER_BYTE;
          end
          if (in_ch.byte_present && count_r == BLOCK_LAST_POS) begin
            ctl.start = 1'b1;
            state_nxt = S_COMP;
          end else if (in_ch.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctl.wr_en = 1'b1;
        count_nxt = count_r + 1'b1;
        if (!mark_done_r) begin
          ctl.wr_byte   = PAD_MARK;
          mark_done_nxt = 1'b1;
        end else if (len_act_r || count_r == LEN_POS) begin
          ctl.wr_byte = len_r[LEN_W-1 -: BYTE_W];
          len_nxt     = {len_r[LEN_W-BYTE_W-1:0], PAD_ZERO};
          len_act_nxt = 1'b1;
          len_cnt_nxt = len_cnt_r + 1'b1;
          if (len_cnt_r == LEN_BYTE_LAST) begin
            pad_last_nxt = 1'b1;
          end
        end else begin
          ctl.wr_byte = PAD_ZERO;
        end
        if (count_r == BLOCK_LAST_POS) begin
          ctl.start = 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (stat.done) begin
          if (pad_last_r) begin
            state_nxt = S_OUT;
          end else if (padding_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          out_idx_nxt = out_idx_r + 1'b1;
          if (out_idx_r == LAST_WORD_IDX) begin
            ctl.reinit    = 1'b1;
            state_nxt     = S_IDLE;
            count_nxt     = '0;
            len_nxt       = '0;
            padding_nxt   = 1'b0;
            mark_done_nxt = 1'b0;
            len_act_nxt   = 1'b0;
            len_cnt_nxt   = '0;
            pad_last_nxt  = 1'b0;
            out_idx_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      padding_r   <= 1'b0;
      mark_done_r <= 1'b0;
      len_act_r   <= 1'b0;
      len_cnt_r   <= '0;
      pad_last_r  <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      padding_r   <= padding_nxt;
      mark_done_r <= mark_done_nxt;
      len_act_r   <= len_act_nxt;
      len_cnt_r   <= len_cnt_nxt;
      pad_last_r  <= pad_last_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  // digest word presented from the chaining words
  assign out_ch.digest_word = chain[out_idx_r];
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = (out_idx_r == LAST_WORD_IDX);

`ifndef ASSERT_OFF
  // no request is taken while the round unit is working
  a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.busy)
    else $error("request accepted while compression busy");

  // a compression starts only on the byte that fills a block
  a_start_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (ctl.wr_en && ctl.wr_pos == BLOCK_LAST_POS))
    else $error("compression started on a partial block");

  // output and intake never overlap
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("digest word shown while taking requests");

  // after the final word the block is back to its initial state
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=>
      (in_ch.ready && chain[0] == INIT_H[0] && len_r == '0))
    else $error("state not restored after digest");
`endif

endmodule

`default_nettype wire

// ----- tb/sha1_message_digest_test.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest_test
// Self-checking bench for the SHA-1 byte-stream digest block. Message bytes
// go in over a valid/ready channel with random bursts and gaps. A software
// SHA-1 model predicts the five digest words of each message. Each word that
// comes out is checked field by field against the oldest prediction. The
// output side stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_test;
  import sha1md_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_REQS     = 330;
  localparam int MIN_MESSAGES    = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 20;
  localparam int TAIL_CYCLES     = 200;
  localparam int STALL_LIMIT     = 5000;
  localparam int BLOCK_BYTES     = int'(BLOCK_LAST_POS) + 1;
  localparam int ROUND_COUNT     = int'(LAST_ROUND) + 1;

  typedef struct packed {
    word_t            digest_word;
    logic [IDX_W-1:0] word_index;
    logic             last_word;
  } digest_entry_t;

  logic clk;
  logic rst_n;

  sha1md_in_if  in_if ();
  sha1md_out_if out_if ();

  sha1_message_digest i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predicted digest words, oldest first
  digest_entry_t pending_digest_q[$];

  // model state: chaining words, current block, fill and bit length
  word_t            hash_words [DIGEST_WORDS];
  word_t            block_words [WIN_WORDS];
  int unsigned      block_fill;
  logic [LEN_W-1:0] bit_count;

  int fail_count;
  int burst_left;
  int reqs_sent;
  int messages_sent;
  bit hold_request;
  bit steady_send;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic word_t rotl(input word_t v, input int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // back to the initial hash and an empty message
  function automatic void clear_digest_state();
    for (int i = 0; i < DIGEST_WORDS; i++) hash_words[i] = INIT_H[i];
    for (int i = 0; i < WIN_WORDS; i++) block_words[i] = '0;
    block_fill = 0;
    bit_count  = '0;
  endfunction

  // 80 rounds over the held block, folded into the chaining words
  function automatic void compress_block();
    word_t w [WIN_WORDS];
    word_t a, b, c, d, e, f, k, t_word, sched;
    for (int i = 0; i < WIN_WORDS; i++) w[i] = block_words[i];
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int r = 0; r < ROUND_COUNT; r++) begin
      if (r < WIN_WORDS) begin
        sched = w[r];
      end else begin
        sched = rotl(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = sched;
      end
      if (r < PHASE1_START) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < PHASE2_START) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < PHASE3_START) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t_word = rotl(a, 5) + f + e + k + sched;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t_word;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  // big-endian packing of one byte, compress on a full block
  function automatic void absorb_byte(input logic [BYTE_W-1:0] value);
    int unsigned slot, shift;
    slot  = block_fill >> 2;
    shift = (3 - (block_fill & 3)) * 8;
    if ((block_fill & 3) == 0) block_words[slot] = '0;
    block_words[slot] |= word_t'(value) << shift;
    block_fill++;
    if (block_fill == BLOCK_BYTES) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // one accepted request: absorb, and on the end mark pad and queue the digest
  function automatic void predict_digest(input logic [BYTE_W-1:0] data,
                                         input logic present, input logic closing);
    logic [LEN_W-1:0] msg_len;
    digest_entry_t    entry;
    if (present) begin
      absorb_byte(data);
      bit_count += BITS_PER_BYTE;
    end
    if (closing) begin
      msg_len = bit_count;
      absorb_byte(PAD_MARK);
      while (block_fill != int'(LEN_POS)) absorb_byte(PAD_ZERO);
      for (int i = int'(LEN_BYTE_LAST); i >= 0; i--) absorb_byte(msg_len[i*8 +: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        entry.digest_word = hash_words[i];
        entry.word_index  = IDX_W'(i);
        entry.last_word   = (i == DIGEST_WORDS - 1);
        pending_digest_q.insert(pending_digest_q.size(), entry);
      end
      clear_digest_state();
    end
  endfunction

  // send one request, with a random gap whenever a burst runs out, unless sending is steady
  task automatic send_req(input logic [BYTE_W-1:0] data, input logic present,
                          input logic closing);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      if (!steady_send) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.byte_present   <= present;
    in_if.end_of_message <= closing;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_digest(data, present, closing);
    if (present || closing) reqs_sent++;
  endtask

  // one message of random bytes, closed by its last byte or a bare end mark
  task automatic send_message(input int len, input bit bare_end, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_req(BYTE_W'($urandom), 1'b0, 1'b0);
      send_req(BYTE_W'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_req(BYTE_W'($urandom), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // sender pauses until every predicted word has come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // empty message closed by a bare end mark
  task automatic test_empty_message();
    send_message(0, 1'b1, 0);
  endtask

  // one-byte messages at the byte extremes
  task automatic test_byte_extremes();
    send_req(8'h00, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b1);
  endtask

  // the classic "abc" message
  task automatic test_abc_message();
    send_req(8'h61, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0);
    send_req(8'h63, 1'b1, 1'b1);
  endtask

  // bytes followed by a bare end mark carrying a stray data byte
  task automatic test_bare_end();
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hA5, 1'b0, 1'b1);
  endtask

  // idle requests mixed into a message change nothing
  task automatic test_idle_items();
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(8'h5A, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'hC3, 1'b1, 1'b1);
  endtask

  // receiver holds off while short messages keep coming, so the input stalls
  task automatic test_output_hold();
    hold_request = 1'b1;
    steady_send  = 1'b1;
    repeat (4) send_message($urandom_range(1, 3), 1'b0, 0);
    steady_send = 1'b0;
    wait_for_drain();
  endtask

  // random messages, mostly short, some on block boundaries, a few long
  task automatic test_random_messages();
    int boundary_len [8];
    int pick, len;
    bit bare;
    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
    reqs_sent     = 0;
    messages_sent = 0;
    while (reqs_sent < RANDOM_REQS || messages_sent < MIN_MESSAGES) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        len = $urandom_range(0, 15);
      end else if (pick < 18) begin
        len = boundary_len[$urandom_range(0, 7)];
      end else begin
        len = $urandom_range(100, 130);
      end
      bare        = ($urandom_range(0, 3) == 0);
      steady_send = ($urandom_range(0, 3) == 0);
      send_message(len, bare, 8);
      steady_send = 1'b0;
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end
  endtask

  // stimulus and end of run
  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.byte_present   = 1'b0;
    in_if.end_of_message = 1'b0;
    fail_count           = 0;
    burst_left           = 0;
    reqs_sent            = 0;
    messages_sent        = 0;
    hold_request         = 1'b0;
    steady_send          = 1'b0;
    clear_digest_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_byte_extremes();
    test_abc_message();
    test_bare_end();
    test_idle_items();
    wait_for_drain();
    test_output_hold();
    test_random_messages();

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_message_digest test passed");
    end else begin
      $display("sha1_message_digest test failed");
    end
    $finish;
  end

  // receiver: random stall modes, and a long hold-off on request
  initial begin
    int mode, mode_left, hold_left, phase;
    logic [31:0] mask;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    mask      = '1;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        if (hold_left == 0) hold_left = HOLD_OFF_CYCLES;
        out_if.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
          mask      = $urandom;
        end
        mode_left--;
        phase = (phase + 1) % 32;
        case (mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= mask[phase];
          end
          default: begin
            out_if.ready <= (phase % 4) == 0;
          end
        endcase
      end
    end
  end

  // compare each digest word with the oldest prediction
  always @(posedge clk) begin : check_digest
    digest_entry_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_digest_q.size() == 0) begin
        $error("digest_word: no result expected, got %h", out_if.digest_word);
        fail_count++;
      end else begin
        want = pending_digest_q.pop_front();
        if (out_if.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, out_if.digest_word);
          fail_count++;
        end
        if (out_if.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, out_if.word_index);
          fail_count++;
        end
        if (out_if.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word, out_if.last_word);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sha1_message_digest test failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
